### rtl/core/cprg_pkg.sv
// Shared types, constants and helpers for the camera ray generator.
`default_nettype none
package cprg_pkg;

    localparam int CMP_W  = 21;
    localparam int DIR_W  = 18;
    localparam int SQ_W   = 59;
    localparam int ROOT_STAGES = 29;
    localparam int QUO_BITS    = 17;

    typedef logic signed [CMP_W-1:0] cmp_t;
    typedef cmp_t [2:0] vec_t;
    typedef logic signed [DIR_W-1:0] dcmp_t;
    typedef dcmp_t [2:0] dvec_t;

    typedef enum logic [2:0] {
        REG_EYE   = 3'd0,
        REG_BASE  = 3'd1,
        REG_STEPX = 3'd2,
        REG_STEPY = 3'd3,
        REG_LENSX = 3'd4,
        REG_LENSY = 3'd5,
        REG_RATIO = 3'd6,
        REG_MODE  = 3'd7
    } reg_idx_t;

    localparam logic [23:0] RATIO_RESET = 24'd65536;

    // Clamp a wide signed value to the 21-bit component range.
    function automatic cmp_t sat21(input logic signed [47:0] v);
        cmp_t r;
        if (v > 48'sd1048575)
        begin
            r = 21'sd1048575;
        end
        else if (v < -48'sd1048576)
        begin
            r = -21'sd1048576;
        end
        else
        begin
            r = v[CMP_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/cprg_norm.sv
// Pipelined square root and per-component division for direction normalization.
`default_nettype none
module cprg_norm
    import cprg_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [SQ_W-1:0] in_n,
    input  wire vec_t            in_dir,
    input  wire vec_t            in_org,
    output logic                 out_valid,
    output vec_t                 out_org,
    output dvec_t                out_dir
);

    // Square root stages: one result bit per stage.
    logic [SQ_W-1:0] sq_n_reg [0:ROOT_STAGES];
    logic [SQ_W-1:0] sq_r_reg [0:ROOT_STAGES];
    logic            sq_v_reg [0:ROOT_STAGES];
    vec_t            sq_d_reg [0:ROOT_STAGES];
    vec_t            sq_o_reg [0:ROOT_STAGES];

    always_comb
    begin
        sq_n_reg[0] = in_n;
        sq_r_reg[0] = '0;
        sq_v_reg[0] = in_valid;
        sq_d_reg[0] = in_dir;
        sq_o_reg[0] = in_org;
    end

    for (genvar j = 0; j < ROOT_STAGES; j++)
    begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STAGES - 1 - j));
        logic [SQ_W-1:0] trial;
        assign trial = sq_r_reg[j] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[j+1] <= sq_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sq_n_reg[j] >= trial)
                begin
                    sq_n_reg[j+1] <= sq_n_reg[j] - trial;
                    sq_r_reg[j+1] <= (sq_r_reg[j] >> 1) + BIT;
                end
                else
                begin
                    sq_n_reg[j+1] <= sq_n_reg[j];
                    sq_r_reg[j+1] <= sq_r_reg[j] >> 1;
                end
                sq_d_reg[j+1] <= sq_d_reg[j];
                sq_o_reg[j+1] <= sq_o_reg[j];
            end
        end
    end

    // Restoring division stages: one quotient bit per stage, all three lanes.
    localparam int REM_W = 46;
    logic [REM_W-1:0]    dv_rem_reg [0:QUO_BITS][3];
    logic [QUO_BITS-1:0] dv_q_reg   [0:QUO_BITS][3];
    logic [2:0]          dv_neg_reg [0:QUO_BITS];
    logic [28:0]         dv_s_reg   [0:QUO_BITS];
    logic                dv_v_reg   [0:QUO_BITS];
    vec_t                dv_o_reg   [0:QUO_BITS];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [CMP_W-1:0] mag;
            mag = sq_d_reg[ROOT_STAGES][c][CMP_W-1]
                ? CMP_W'(-sq_d_reg[ROOT_STAGES][c]) : sq_d_reg[ROOT_STAGES][c];
            dv_rem_reg[0][c] = {1'b0, mag, 24'd0};
            dv_q_reg[0][c]   = '0;
            dv_neg_reg[0][c] = sq_d_reg[ROOT_STAGES][c][CMP_W-1];
        end
        dv_s_reg[0] = sq_r_reg[ROOT_STAGES][28:0];
        dv_v_reg[0] = sq_v_reg[ROOT_STAGES];
        dv_o_reg[0] = sq_o_reg[ROOT_STAGES];
    end

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_div
        localparam int SH = QUO_BITS - 1 - i;
        logic [REM_W-1:0] dvs;
        assign dvs = REM_W'(dv_s_reg[i]) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[i+1] <= dv_v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (dv_rem_reg[i][c] >= dvs)
                    begin
                        dv_rem_reg[i+1][c] <= dv_rem_reg[i][c] - dvs;
                        dv_q_reg[i+1][c]   <= dv_q_reg[i][c] | (QUO_BITS'(1) << SH);
                    end
                    else
                    begin
                        dv_rem_reg[i+1][c] <= dv_rem_reg[i][c];
                        dv_q_reg[i+1][c]   <= dv_q_reg[i][c];
                    end
                end
                dv_neg_reg[i+1] <= dv_neg_reg[i];
                dv_s_reg[i+1]   <= dv_s_reg[i];
                dv_o_reg[i+1]   <= dv_o_reg[i];
            end
        end
    end

    // Apply signs; a zero root means a zero vector.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [DIR_W-1:0] qe;
            qe = {1'b0, dv_q_reg[QUO_BITS][c]};
            if (dv_s_reg[QUO_BITS] == '0)
            begin
                out_dir[c] = '0;
            end
            else
            begin
                out_dir[c] = dv_neg_reg[QUO_BITS][c] ? -qe : qe;
            end
        end
    end

    assign out_valid = dv_v_reg[QUO_BITS];
    assign out_org   = dv_o_reg[QUO_BITS];

endmodule
`default_nettype wire

### rtl/core/camera_primary_ray_generator.sv
// Top level of the pinhole and thin-lens camera ray generator.
//
// Channel  Dir  Handshake            Payload
// s_axis   in   s_tvalid/s_tready    pixel_x, pixel_y, lens_u, lens_v
// m_axis   out  m_tvalid/m_tready    origin_x/y/z, dir_x/y/z
// cfg      in   cfg_we               cfg_index, cfg_data
//
// One item enters per cycle while the output is not stalled; the pipeline has six arithmetic stages,
// 29 square root stages (one root bit each) and 17 divider stages.
// Reset clears the valid bits and loads the register reset values.
// When the output item is not taken, the whole pipeline holds in place.
`default_nettype none
module camera_primary_ray_generator
    import cprg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // pixel_x, pixel_y, lens_u, lens_v
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [119:0]      m_tdata,   // origin_x/y/z, dir_x/y/z, 3 zero bits
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [62:0]  cfg_data
);

    // Configuration registers.
    vec_t        eye_reg, base_reg, sx_reg, sy_reg, lx_reg, ly_reg;
    logic [23:0] ratio_reg;
    logic        mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg   <= '0;
            base_reg  <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            lx_reg    <= '0;
            ly_reg    <= '0;
            ratio_reg <= RATIO_RESET;
            mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_EYE:   eye_reg   <= cfg_data;
                REG_BASE:  base_reg  <= cfg_data;
                REG_STEPX: sx_reg    <= cfg_data;
                REG_STEPY: sy_reg    <= cfg_data;
                REG_LENSX: lx_reg    <= cfg_data;
                REG_LENSY: ly_reg    <= cfg_data;
                REG_RATIO: ratio_reg <= cfg_data[23:0];
                REG_MODE:  mode_reg  <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    logic  en;
    logic  nv_out;
    vec_t  n_org;
    dvec_t n_dir;

    assign en       = !nv_out || m_tready;
    assign s_tready = en;

    logic [15:0] px, py;
    logic signed [15:0] lu, lv;
    assign px = s_tdata[15:0];
    assign py = s_tdata[31:16];
    assign lu = s_tdata[47:32];
    assign lv = s_tdata[63:48];

    // Stage 1: per-pixel and lens products.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [37:0] pxs_reg [3], pys_reg [3];
    logic signed [36:0] ul_reg [3], vl_reg [3];

    // Stage 2 through 6 payload.
    vec_t pin_reg, org_reg, pin3_reg, org3_reg, dir4_reg, org4_reg, dir5_reg, org5_reg;
    vec_t dir6_reg, org6_reg;
    logic signed [45:0] fp_reg [3];
    logic [40:0] sq_reg [3];
    logic [SQ_W-1:0] n6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1: exact products.
            for (int c = 0; c < 3; c++)
            begin
                pxs_reg[c] <= 38'($signed({1'b0, px}) * sx_reg[c]);
                pys_reg[c] <= 38'($signed({1'b0, py}) * sy_reg[c]);
                ul_reg[c]  <= 37'(lu * lx_reg[c]);
                vl_reg[c]  <= 37'(lv * ly_reg[c]);
            end
            // Stage 2: sums, floor shift and clamp.
            for (int c = 0; c < 3; c++)
            begin
                logic signed [39:0] acc, oacc;
                acc  = 40'(base_reg[c]) * 40'sd16 + 40'(pxs_reg[c]) + 40'(pys_reg[c]);
                oacc = 40'(eye_reg[c]) * 40'sd16384 + 40'(ul_reg[c]) + 40'(vl_reg[c]);
                pin_reg[c] <= sat21(48'(acc >>> 4));
                org_reg[c] <= mode_reg ? sat21(48'(oacc >>> 14)) : eye_reg[c];
            end
            // Stage 3: focal ratio product.
            for (int c = 0; c < 3; c++)
            begin
                fp_reg[c] <= 46'($signed({1'b0, ratio_reg}) * pin_reg[c]);
            end
            org3_reg <= org_reg;
            pin3_reg <= pin_reg;
            // Stage 4: focal point and direction.
            for (int c = 0; c < 3; c++)
            begin
                cmp_t focal;
                focal = sat21(48'(eye_reg[c]) + 48'(fp_reg[c] >>> 16));
                dir4_reg[c] <= mode_reg ? sat21(48'(focal) - 48'(org3_reg[c]))
                                        : pin3_reg[c];
            end
            org4_reg <= org3_reg;
            // Stage 5: squares.
            for (int c = 0; c < 3; c++)
            begin
                sq_reg[c] <= 41'(dir4_reg[c] * dir4_reg[c]);
            end
            dir5_reg <= dir4_reg;
            org5_reg <= org4_reg;
            // Stage 6: squared length scaled for the root.
            n6_reg   <= (SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2])) << 16;
            dir6_reg <= dir5_reg;
            org6_reg <= org5_reg;
        end
    end

    cprg_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .in_n      (n6_reg),
        .in_dir    (dir6_reg),
        .in_org    (org6_reg),
        .out_valid (nv_out),
        .out_org   (n_org),
        .out_dir   (n_dir)
    );

    assign m_tvalid = nv_out;
    assign m_tdata  = {3'b000, n_dir[2], n_dir[1], n_dir[0], n_org[2], n_org[1], n_org[0]};

endmodule
`default_nettype wire
